// ===== sv/skaf_pkg.sv =====
// skaf_pkg: shared types and constants of the scalar Kalman angle fusion core.
// No dependencies; used by the controller, the datapath and the top level.
package skaf_pkg;

   // Configuration register port; indexes above the last register are dropped
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROCESS_NOISE     = 2'd0,
      CSR_MEASUREMENT_NOISE = 2'd1
   } csr_index_type;

   localparam logic [31:0] PROCESS_NOISE_RESET     = 32'd65;
   localparam logic [31:0] MEASUREMENT_NOISE_RESET = 32'd65536;

   // Error variance after reset: 0.5 in Q16.16
   localparam logic [31:0] VARIANCE_RESET = 32'd32768;

   // Unity gain in Q1.16
   localparam logic [16:0] GAIN_ONE = 17'h10000;

   // Iteration counts of the shared step counter
   localparam int COUNT_W     = 5;
   localparam int DIV_STEPS   = 32;
   localparam int SQRT_STEPS  = 17;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture the accepted item
      logic read;       // read the channel variance
      logic prep;       // predict the variance, set up the divider
      logic div_step;   // one quotient bit
      logic sqrt_step;  // one root bit
      logic mul;        // both products
      logic finish;     // round, store the variance, load the result
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_ready;  // result register free or emptying this cycle
   } status_type;

endpackage

// ===== sv/skaf_ram.sv =====
// skaf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module skaf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/skaf_ctrl.sv =====
// skaf_ctrl: sequencer of the fusion core; steps the datapath through
// read, set-up, divide, square root, multiply and finish. Depends on skaf_pkg.
module skaf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  skaf_pkg::status_type status,
   output skaf_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_READ = 7'b0000010,
      ST_PREP = 7'b0000100,
      ST_DIV  = 7'b0001000,
      ST_SQRT = 7'b0010000,
      ST_MUL  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   state_type                          state_ff, state_in;
   logic [skaf_pkg::COUNT_W-1:0]       count_ff, count_in;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            count_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (count_ff == skaf_pkg::COUNT_W'(skaf_pkg::DIV_STEPS - 1)) begin
               count_in = '0;
               state_in = ST_SQRT;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (count_ff == skaf_pkg::COUNT_W'(skaf_pkg::SQRT_STEPS - 1)) begin
               count_in = '0;
               state_in = ST_MUL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold until the result register can take the item
            if (status.out_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_fin_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && status.out_ready) |=> (state_ff == ST_IDLE))
      else $error("finish did not return to idle");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP) |=> (state_ff == ST_DIV && count_ff == '0))
      else $error("divider did not start from step zero");

   a_state_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

endmodule

// ===== sv/skaf_datapath.sv =====
// skaf_datapath: variance store, restoring divider, bit-pair square root,
// products and rounding of the fusion core. Depends on skaf_pkg, skaf_ram.
module skaf_datapath #(
   parameter int CHANNELS = 8
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  skaf_pkg::cmd_type                            cmd,
   output skaf_pkg::status_type                         status,
   input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] channel_idx,
   input  logic signed [31:0]                           measured_angle,
   input  logic signed [31:0]                           predicted_angle,
   input  logic [31:0]                                  process_noise,
   input  logic [31:0]                                  measurement_noise,
   input  logic                                         rsp_stall,
   output logic                                         rsp_valid,
   output logic signed [31:0]                           rsp_filtered_angle,
   output logic [16:0]                                  rsp_gain
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic signed [35:0] ANGLE_MAX = 36'sd2147483647;
   localparam logic signed [35:0] ANGLE_MIN = -36'sd2147483648;

   // Item capture
   logic [IDX_W-1:0]    ch_ff;
   logic signed [31:0]  meas_ff, pred_ff;

   // Variance store and its valid bits
   logic [CHANNELS-1:0] valid_ff;
   logic [31:0]         var_rd;
   logic [31:0]         nv_sat;

   // Prediction and divider
   logic [31:0]         p_ff;
   logic [32:0]         d_ff;
   logic                dzero_ff;
   logic [32:0]         rem_ff;
   logic [33:0]         q_ff;
   logic signed [32:0]  diff_ff;

   // Square root
   logic [18:0]         srem_ff;
   logic [16:0]         sroot_ff;

   // Products
   logic signed [50:0]  prod_a_ff;
   logic [48:0]         prod_b_ff;

   // Result register
   logic                rsp_valid_ff;
   logic signed [31:0]  rsp_filtered_ff;
   logic [16:0]         rsp_gain_ff;

   // Combinational terms
   logic [31:0]         var_cur;
   logic [32:0]         p_sum;
   logic [31:0]         p_val;
   logic [32:0]         d_val;
   logic                d_ge;
   logic [33:0]         div_sh, div_dd;
   logic                div_take;
   logic [20:0]         sq_rem4, sq_trial;
   logic                sq_take;
   logic [16:0]         gain_comp;
   logic signed [50:0]  ra_sum, ra_shift;
   logic signed [35:0]  f_sum;
   logic signed [31:0]  f_clamped;
   logic [49:0]         nv_sum;

   skaf_ram #(
      .WIDTH(32),
      .DEPTH(CHANNELS)
   ) u_var_ram (
      .clock  (clock),
      .wr_en  (cmd.finish),
      .wr_addr(ch_ff),
      .wr_data(nv_sat),
      .rd_en  (cmd.read),
      .rd_addr(ch_ff),
      .rd_data(var_rd)
   );

   always_comb begin
      // a channel never written reads as the reset variance
      var_cur = valid_ff[ch_ff] ? var_rd : skaf_pkg::VARIANCE_RESET;
      p_sum   = {1'b0, var_cur} + {1'b0, process_noise};
      p_val   = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
      d_val   = {1'b0, p_val} + {1'b0, measurement_noise};
      d_ge    = ({1'b0, p_val} >= d_val);

      div_sh   = {rem_ff, 1'b0};
      div_dd   = {1'b0, d_ff};
      div_take = (div_sh >= div_dd);

      sq_rem4  = {srem_ff, q_ff[33:32]};
      sq_trial = {2'b00, sroot_ff, 2'b01};
      sq_take  = (sq_rem4 >= sq_trial);

      gain_comp = skaf_pkg::GAIN_ONE - sroot_ff;

      ra_sum   = prod_a_ff + 51'sd32768;
      ra_shift = ra_sum >>> 16;
      f_sum    = {{4{pred_ff[31]}}, pred_ff} + ra_shift[35:0];
      if (f_sum > ANGLE_MAX) begin
         f_clamped = 32'sh7FFF_FFFF;
      end else if (f_sum < ANGLE_MIN) begin
         f_clamped = 32'sh8000_0000;
      end else begin
         f_clamped = f_sum[31:0];
      end

      nv_sum = {1'b0, prod_b_ff} + 50'd32768;
      nv_sat = nv_sum[48] ? 32'hFFFF_FFFF : nv_sum[47:16];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff   <= channel_idx;
         meas_ff <= measured_angle;
         pred_ff <= predicted_angle;
      end
      if (cmd.prep) begin
         p_ff     <= p_val;
         d_ff     <= d_val;
         dzero_ff <= (d_val == '0);
         // the integer part of p/d is one only when the noise term is zero
         q_ff     <= {33'd0, d_ge && (d_val != '0)};
         rem_ff   <= d_ge ? 33'd0 : {1'b0, p_val};
         diff_ff  <= {meas_ff[31], meas_ff} - {pred_ff[31], pred_ff};
         srem_ff  <= '0;
         sroot_ff <= '0;
      end
      if (cmd.div_step && !dzero_ff) begin
         if (div_take) begin
            rem_ff <= 33'(div_sh - div_dd);
            q_ff   <= {q_ff[32:0], 1'b1};
         end else begin
            rem_ff <= div_sh[32:0];
            q_ff   <= {q_ff[32:0], 1'b0};
         end
      end
      if (cmd.sqrt_step) begin
         srem_ff  <= sq_take ? 19'(sq_rem4 - sq_trial) : sq_rem4[18:0];
         sroot_ff <= {sroot_ff[15:0], sq_take};
         q_ff     <= {q_ff[31:0], 2'b00};
      end
      if (cmd.mul) begin
         prod_a_ff <= $signed({1'b0, sroot_ff}) * diff_ff;
         prod_b_ff <= gain_comp * p_ff;
      end
      if (cmd.finish) begin
         rsp_filtered_ff <= f_clamped;
         rsp_gain_ff     <= sroot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            valid_ff[ch_ff] <= 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_ready   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_angle = rsp_filtered_ff;
   assign rsp_gain           = rsp_gain_ff;

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && !dzero_ff) |-> ({1'b0, rem_ff} < {1'b0, d_ff}))
      else $error("divider remainder not below divisor");

   a_sqrt_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_step |-> (srem_ff <= {1'b0, sroot_ff, 1'b0}))
      else $error("root remainder above twice the partial root");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_gain_ff <= skaf_pkg::GAIN_ONE))
      else $error("gain above one");

endmodule

// ===== sv/scalar_kalman_angle_fusion_core.sv =====
// scalar_kalman_angle_fusion_core: top level of the multi-channel scalar
// Kalman angle fusion. Depends on skaf_pkg, skaf_ctrl, skaf_datapath.
//
//   Channel   Handshake            Payload
//   req       req_valid/req_stall  req_channel, req_measured_angle,
//                                  req_predicted_angle
//   rsp       rsp_valid/rsp_stall  rsp_filtered_angle, rsp_gain
//   csr       csr_write_enable     csr_index, csr_write_data
//
// One item at a time: req_stall stays high from acceptance until the finish
// step of the item. The restoring divider (one quotient bit a cycle) and
// the bit-pair square root (one root bit a cycle) take most of that span
// when the result side does not stall; variance read, set-up, products
// and rounding add the rest.
// Reset is synchronous and needs no clearing pass: valid bits make every
// channel read as 0.5 until first written.
// A result waits in the output register; the next item is taken meanwhile
// and only its finish step waits for that register to empty.
module scalar_kalman_angle_fusion_core #(
   parameter int CHANNELS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // item input
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_channel,
   input  logic signed [31:0]                   req_measured_angle,
   input  logic signed [31:0]                   req_predicted_angle,
   // result output
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [31:0]                   rsp_filtered_angle,
   output logic [16:0]                          rsp_gain,
   // register writes
   input  logic                                 csr_write_enable,
   input  logic [skaf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [skaf_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [31:0]          process_noise_ff;
   logic [31:0]          measurement_noise_ff;
   logic [2:0]           ch_reduced;
   logic [IDX_W-1:0]     channel_idx;
   skaf_pkg::cmd_type    cmd;
   skaf_pkg::status_type status;

   // Register writes: take the data at once, drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         process_noise_ff     <= skaf_pkg::PROCESS_NOISE_RESET;
         measurement_noise_ff <= skaf_pkg::MEASUREMENT_NOISE_RESET;
      end else if (csr_write_enable) begin
         unique case (skaf_pkg::csr_index_type'(csr_index))
            skaf_pkg::CSR_PROCESS_NOISE: begin
               process_noise_ff <= csr_write_data;
            end
            skaf_pkg::CSR_MEASUREMENT_NOISE: begin
               measurement_noise_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Fold the channel number into range by repeated subtraction
   always_comb begin
      ch_reduced = req_channel;
      for (int i = 0; i < 7; i++) begin
         if (int'(ch_reduced) >= CHANNELS) begin
            ch_reduced = ch_reduced - 3'(CHANNELS);
         end
      end
      channel_idx = IDX_W'(ch_reduced);
   end

   skaf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   skaf_datapath #(
      .CHANNELS(CHANNELS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .channel_idx       (channel_idx),
      .measured_angle    (req_measured_angle),
      .predicted_angle   (req_predicted_angle),
      .process_noise     (process_noise_ff),
      .measurement_noise (measurement_noise_ff),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_filtered_angle(rsp_filtered_angle),
      .rsp_gain          (rsp_gain)
   );

endmodule
